// ===== hw/rtl/priority_ready_queue_scheduler_defines.svh =====
// Assertion macros for the priority ready queue scheduler
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define PRQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("prq check failed");

// next-cycle implication, sampled on clock, off during reset
`define PRQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("prq check failed");

`endif

// ===== hw/rtl/prq_pkg.sv =====
// Shared codes and field widths of the priority ready queue scheduler
`default_nettype none

package prq_pkg;

   localparam int OP_W     = 3;
   localparam int ID_W     = 8;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_SCHEDULE = 3'd2,
      OP_LOCK     = 3'd3,
      OP_UNLOCK   = 3'd4
   } prq_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } prq_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/prq_if.sv =====
// Request and response channel interfaces of the priority ready queue scheduler
`default_nettype none

interface prq_req_if
   import prq_pkg::*;
   (input wire logic clock);
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ID_W-1:0]   task_id;
   logic [PRIO_W-1:0] priority_req;

   modport source (input clock, output valid, output operation, output task_id,
                   output priority_req, input ready);
   modport sink   (input clock, input valid, input operation, input task_id,
                   input priority_req, output ready);
endinterface

interface prq_rsp_if
   import prq_pkg::*;
   (input wire logic clock);
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     next_task;
   logic                switch_needed;
   logic                save_previous;
   logic [ID_W-1:0]     previous_task;
   logic                locked;

   modport source (input clock, output valid, output status, output next_task,
                   output switch_needed, output save_previous, output previous_task,
                   output locked, input ready);
   modport sink   (input clock, input valid, input status, input next_task,
                   input switch_needed, input save_previous, input previous_task,
                   input locked, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/priority_ready_queue_scheduler.sv =====
// Priority ready queue scheduler top level
//
// Keeps up to QUEUE_DEPTH task ids sorted by priority (lower value first, equal
// priorities in arrival order) in a single entry memory with a registered read.
// One request is worked at a time; every request gives one response beat.
// Each touch of an entry is a read-then-write step of the sequencer: insert
// walks from the tail toward its position, remove walks the whole queue and
// schedule reads only the head. A new request is taken in the cycle after the
// response is registered, even while that response still waits for ready.
// Schedule does not dequeue the head; remove takes the first matching id.
// Queue entries need no clearing after reset: only entries below the fill count
// are ever read.
`default_nettype none

module priority_ready_queue_scheduler
   import prq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = 16,
   parameter int TASK_ID_BITS  = 8,
   parameter int PRIORITY_BITS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   prq_req_if.sink   req_chan,
   prq_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int EW = TASK_ID_BITS + PRIORITY_BITS;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   prq_ctrl #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .TASK_ID_BITS  (TASK_ID_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   prq_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/prq_ram.sv =====
// Queue entry memory: one write port, one read port, registered read data
`default_nettype none

module prq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/prq_ctrl.sv =====
// Operation sequencer: walks the sorted entry memory one entry per step
`default_nettype none

module prq_ctrl
   import prq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = 16,
   parameter int TASK_ID_BITS  = 8,
   parameter int PRIORITY_BITS = 8,
   localparam int AW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1),
   localparam int EW = TASK_ID_BITS + PRIORITY_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   prq_req_if.sink            req_chan,
   prq_rsp_if.source          rsp_chan,
   output logic               ram_wr_en,
   output logic [AW-1:0]      ram_wr_addr,
   output logic [EW-1:0]      ram_wr_data,
   output logic               ram_rd_en,
   output logic [AW-1:0]      ram_rd_addr,
   input  wire logic [EW-1:0] ram_rd_data
);

   typedef struct packed {
      logic [TASK_ID_BITS-1:0]  task_id;
      logic [PRIORITY_BITS-1:0] prio;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_STEP,
      S_EVAL,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   prq_op_type               op_ff, op_in;
   logic [TASK_ID_BITS-1:0]  id_ff, id_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic                     found_ff, found_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [TASK_ID_BITS-1:0]  current_ff, current_in;
   logic [TASK_ID_BITS-1:0]  nxt_ff, nxt_in;
   logic                     lock_ff, lock_in;
   prq_status_type           st_ff, st_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   prq_status_type           rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]          rsp_next_ff, rsp_next_in;
   logic                     rsp_switch_ff, rsp_switch_in;
   logic                     rsp_save_ff, rsp_save_in;
   logic [ID_W-1:0]          rsp_prev_ff, rsp_prev_in;
   logic                     rsp_locked_ff, rsp_locked_in;

   entry_type                rd_entry;
   entry_type                new_entry;
   logic [CW-1:0]            idx_dec;
   logic                     accept;
   logic                     switch_now;

   assign rd_entry  = entry_type'(ram_rd_data);
   assign new_entry = '{task_id: id_ff, prio: prio_ff};
   assign idx_dec   = idx_ff - CW'(1);
   assign accept    = req_chan.valid && req_chan.ready;
   assign switch_now = (nxt_ff != current_ff);

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.next_task     = rsp_next_ff;
   assign rsp_chan.switch_needed = rsp_switch_ff;
   assign rsp_chan.save_previous = rsp_save_ff;
   assign rsp_chan.previous_task = rsp_prev_ff;
   assign rsp_chan.locked        = rsp_locked_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      current_in    = current_ff;
      nxt_in        = nxt_ff;
      lock_in       = lock_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_switch_in = rsp_switch_ff;
      rsp_save_in   = rsp_save_ff;
      rsp_prev_in   = rsp_prev_ff;
      rsp_locked_in = rsp_locked_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff[AW-1:0];
      ram_wr_data   = new_entry;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = prq_op_type'(req_chan.operation);
               id_in    = TASK_ID_BITS'(req_chan.task_id);
               prio_in  = PRIORITY_BITS'(req_chan.priority_req);
               st_in    = ST_OK;
               found_in = 1'b0;
               idx_in   = (prq_op_type'(req_chan.operation) == OP_INSERT) ? count_ff : '0;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            case (op_ff)
               OP_INSERT: begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     st_in    = ST_FULL;
                     state_in = S_DONE;
                  end else if (idx_ff == '0) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = '0;
                     count_in    = count_ff + CW'(1);
                     state_in    = S_DONE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = idx_dec[AW-1:0];
                     state_in    = S_EVAL;
                  end
               end
               OP_REMOVE: begin
                  if (idx_ff == count_ff) begin
                     if (found_ff) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        st_in = ST_NOT_FOUND;
                     end
                     state_in = S_DONE;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = S_EVAL;
                  end
               end
               OP_SCHEDULE: begin
                  if (lock_ff) begin
                     nxt_in   = current_ff;
                     state_in = S_DONE;
                  end else if (count_ff == '0) begin
                     nxt_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = S_EVAL;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_EVAL: begin
            case (op_ff)
               OP_INSERT: begin
                  ram_wr_en = 1'b1;
                  if (rd_entry.prio > prio_ff) begin
                     ram_wr_data = rd_entry;
                     idx_in      = idx_dec;
                     state_in    = S_STEP;
                  end else begin
                     count_in = count_ff + CW'(1);
                     state_in = S_DONE;
                  end
               end
               OP_REMOVE: begin
                  // close the gap: move each entry past the match down by one
                  if (found_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = idx_dec[AW-1:0];
                     ram_wr_data = rd_entry;
                  end else if (rd_entry.task_id == id_ff) begin
                     found_in = 1'b1;
                  end
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_STEP;
               end
               OP_SCHEDULE: begin
                  nxt_in   = rd_entry.task_id;
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_prev_in   = ID_W'(current_ff);
               rsp_switch_in = 1'b0;
               rsp_save_in   = 1'b0;
               rsp_next_in   = ID_W'(current_ff);
               rsp_locked_in = lock_ff;
               case (op_ff)
                  OP_SCHEDULE: begin
                     current_in    = nxt_ff;
                     rsp_next_in   = ID_W'(nxt_ff);
                     rsp_switch_in = switch_now;
                     rsp_save_in   = switch_now && (current_ff != '0);
                  end
                  OP_LOCK: begin
                     lock_in       = 1'b1;
                     rsp_locked_in = 1'b1;
                  end
                  OP_UNLOCK: begin
                     lock_in       = 1'b0;
                     rsp_locked_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         current_ff    <= '0;
         lock_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         current_ff    <= current_in;
         lock_ff       <= lock_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      nxt_ff        <= nxt_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_switch_ff <= rsp_switch_in;
      rsp_save_ff   <= rsp_save_in;
      rsp_prev_ff   <= rsp_prev_in;
      rsp_locked_ff <= rsp_locked_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/prq_checker.sv =====
// Port-level checks of the priority ready queue scheduler and their bind
`default_nettype none
`include "priority_ready_queue_scheduler_defines.svh"

module prq_checker
   import prq_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [ID_W-1:0]     rsp_next_task,
   input wire logic                rsp_switch_needed,
   input wire logic                rsp_save_previous,
   input wire logic [ID_W-1:0]     rsp_previous_task
);

   // one request in flight: no second beat right behind the first
   `PRQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // save only when switching away from a real task
   `PRQ_ASSERT_NOW(a_save_needs_switch, rsp_valid && rsp_save_previous,
                   rsp_switch_needed && (rsp_previous_task != '0))

   // a switch always changes the current task
   `PRQ_ASSERT_NOW(a_switch_changes, rsp_valid && rsp_switch_needed,
                   (rsp_next_task != rsp_previous_task) && (rsp_status == ST_OK))

   // hold a stalled response beat
   `PRQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_next_task) && $stable(rsp_status))

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_next_task     (rsp_chan.next_task),
   .rsp_switch_needed (rsp_chan.switch_needed),
   .rsp_save_previous (rsp_chan.save_previous),
   .rsp_previous_task (rsp_chan.previous_task)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the priority ready queue scheduler, checked against its own queue predictor
`timescale 1ns / 100ps

module tb_top;
   import prq_pkg::*;

   localparam int QUEUE_SLOTS = 16;
   localparam int PHASE_ITEMS = 256;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      prq_status_type  status;
      logic [ID_W-1:0] next_task;
      logic            switch_needed;
      logic            save_previous;
      logic [ID_W-1:0] previous_task;
      logic            locked;
   } prq_rsp_type;

   class prq_scoreboard_type;
      logic [ID_W-1:0]   queue_task [QUEUE_SLOTS];
      logic [PRIO_W-1:0] queue_prio [QUEUE_SLOTS];
      int unsigned       fill = 0;
      logic [ID_W-1:0]   running_task = '0;
      logic              lock_on = 1'b0;
      prq_rsp_type       awaited [$];
      int unsigned       mismatches = 0;

      function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [PRIO_W-1:0] prio);
         prq_rsp_type     want;
         int unsigned     pos;
         logic [ID_W-1:0] head;
         want.status        = ST_OK;
         want.switch_needed = 1'b0;
         want.save_previous = 1'b0;
         want.previous_task = running_task;
         pos = 0;
         case (op)
            OP_INSERT: begin
               if (fill >= QUEUE_SLOTS) begin
                  want.status = ST_FULL;
               end else begin
                  while (pos < fill && queue_prio[pos] <= prio) pos++;
                  for (int k = fill; k > pos; k--) begin
                     queue_task[k] = queue_task[k-1];
                     queue_prio[k] = queue_prio[k-1];
                  end
                  queue_task[pos] = id;
                  queue_prio[pos] = prio;
                  fill++;
               end
            end
            OP_REMOVE: begin
               while (pos < fill && queue_task[pos] != id) pos++;
               if (pos >= fill) begin
                  want.status = ST_NOT_FOUND;
               end else begin
                  for (int k = pos; k + 1 < fill; k++) begin
                     queue_task[k] = queue_task[k+1];
                     queue_prio[k] = queue_prio[k+1];
                  end
                  fill--;
               end
            end
            OP_SCHEDULE: begin
               if (!lock_on) begin
                  head = (fill > 0) ? queue_task[0] : '0;
                  if (head != running_task) begin
                     want.switch_needed = 1'b1;
                     want.save_previous = (running_task != '0);
                  end
                  running_task = head;
               end
            end
            OP_LOCK:   lock_on = 1'b1;
            OP_UNLOCK: lock_on = 1'b0;
            default: ;
         endcase
         want.next_task = running_task;
         want.locked    = lock_on;
         awaited.push_back(want);
      endfunction

      function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(prq_rsp_type got);
         prq_rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual status %0d next %0h",
                     $time, got.status, got.next_task);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("next_task", want.next_task, got.next_task);
         compare_field("switch_needed", want.switch_needed, got.switch_needed);
         compare_field("save_previous", want.save_previous, got.save_previous);
         compare_field("previous_task", want.previous_task, got.previous_task);
         compare_field("locked", want.locked, got.locked);
      endfunction
   endclass

   logic               clock;
   logic               reset;
   prq_scoreboard_type sb;
   int unsigned        send_idle_pct;
   int unsigned        stall_pct;
   int unsigned        items_sent;
   int unsigned        cycles;

   prq_req_if req_chan (.clock(clock));
   prq_rsp_if rsp_chan (.clock(clock));

   priority_ready_queue_scheduler i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 3) == 0) return ID_W'($urandom_range(0, 7));
      return ID_W'($urandom);
   endfunction

   function automatic logic [PRIO_W-1:0] pick_prio();
      if ($urandom_range(0, 1) == 0) return PRIO_W'($urandom_range(8'h7e, 8'h81));
      return PRIO_W'($urandom);
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] prio);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.task_id      <= id;
      req_chan.priority_req <= prio;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(op, id, prio);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic mixed_item();
      int unsigned       roll;
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   id;
      roll = $urandom_range(0, 99);
      id   = pick_id();
      if (roll < 38) begin
         op = OP_INSERT;
      end else if (roll < 62) begin
         op = OP_REMOVE;
         if (sb.fill > 0 && $urandom_range(0, 4) != 0)
            id = sb.queue_task[$urandom_range(0, sb.fill - 1)];
      end else if (roll < 86) begin
         op = OP_SCHEDULE;
      end else if (roll < 92) begin
         op = OP_LOCK;
      end else if (roll < 98) begin
         op = OP_UNLOCK;
      end else begin
         op = OP_W'($urandom_range(5, 7));
      end
      send_request(op, id, pick_prio());
   endtask

   task automatic fill_queue();
      while (sb.fill < QUEUE_SLOTS) begin
         if ($urandom_range(0, 5) == 0) send_request(OP_SCHEDULE, pick_id(), pick_prio());
         else send_request(OP_INSERT, pick_id(), pick_prio());
      end
      repeat ($urandom_range(1, 3)) send_request(OP_INSERT, pick_id(), pick_prio());
   endtask

   task automatic empty_queue();
      while (sb.fill > 0) begin
         if ($urandom_range(0, 5) == 0)
            send_request(OP_SCHEDULE, pick_id(), pick_prio());
         else
            send_request(OP_REMOVE, sb.queue_task[$urandom_range(0, sb.fill - 1)], pick_prio());
      end
      send_request(OP_REMOVE, pick_id(), pick_prio());
      send_request(OP_SCHEDULE, pick_id(), pick_prio());
   endtask

   task automatic run_directed();
      send_request(OP_SCHEDULE, 8'h00, 8'h00);
      send_request(OP_REMOVE,   8'h12, 8'h00);
      send_request(OP_INSERT,   8'hff, 8'hff);
      send_request(OP_INSERT,   8'h00, 8'h00);
      send_request(OP_INSERT,   8'h55, 8'h80);
      send_request(OP_INSERT,   8'haa, 8'h80);
      send_request(OP_INSERT,   8'h55, 8'h80);
      send_request(OP_SCHEDULE, 8'h00, 8'h00);
      send_request(OP_REMOVE,   8'h00, 8'h00);
      send_request(OP_SCHEDULE, 8'h00, 8'h00);
      send_request(OP_LOCK,     8'h00, 8'h00);
      send_request(OP_LOCK,     8'h00, 8'h00);
      send_request(OP_REMOVE,   8'h55, 8'h00);
      send_request(OP_SCHEDULE, 8'h00, 8'h00);
      send_request(OP_UNLOCK,   8'h00, 8'h00);
      send_request(OP_UNLOCK,   8'h00, 8'h00);
      send_request(OP_SCHEDULE, 8'h00, 8'h00);
      send_request(OP_INSERT,   8'h01, 8'h80);
      send_request(OP_W'(5),    8'hff, 8'hff);
      send_request(OP_W'(6),    8'h00, 8'h00);
      send_request(OP_W'(7),    8'hff, 8'hff);
      send_request(OP_REMOVE,   8'haa, 8'h00);
      send_request(OP_REMOVE,   8'h55, 8'h00);
      send_request(OP_SCHEDULE, 8'h00, 8'h00);
      send_request(OP_SCHEDULE, 8'h00, 8'h00);
      send_request(OP_REMOVE,   8'h01, 8'h00);
      send_request(OP_REMOVE,   8'hff, 8'h00);
      send_request(OP_SCHEDULE, 8'h00, 8'h00);
   endtask

   initial begin
      prq_rsp_type got;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.status        = prq_status_type'(rsp_chan.status);
            got.next_task     = rsp_chan.next_task;
            got.switch_needed = rsp_chan.switch_needed;
            got.save_previous = rsp_chan.save_previous;
            got.previous_task = rsp_chan.previous_task;
            got.locked        = rsp_chan.locked;
            sb.check_response(got);
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned phase_start;
      sb                    = new;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = '0;
      req_chan.task_id      = '0;
      req_chan.priority_req = '0;
      send_idle_pct         = 0;
      stall_pct             = 0;
      items_sent            = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_for_drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         phase_start = items_sent;
         fill_queue();
         empty_queue();
         while (items_sent - phase_start < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0: fill_queue();
               1: empty_queue();
               default: repeat (20) mixed_item();
            endcase
         end
         // hold off until every response has come back
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/prq_pkg.sv
hw/rtl/prq_if.sv
hw/rtl/prq_ram.sv
hw/rtl/prq_ctrl.sv
hw/rtl/priority_ready_queue_scheduler.sv
hw/rtl/prq_checker.sv
dv/tb_top.sv
